@@ rtl/sfe_pkg.sv @@
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stereo feedback echo: sample and gain
// widths, history geometry, register codes and the lane control bundle.
// ----------------------------------------------------------------------------
package sfe_pkg;

	// Sample and gain formats
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 14;
	localparam int PROD_W    = SAMPLE_W + GAIN_W;
	localparam int SUM_W     = PROD_W + 1;

	// History geometry (power of two, so indexes wrap naturally)
	localparam int HIST_AW     = 12;
	localparam int HIST_FRAMES = 2 ** HIST_AW;
	localparam int DELAY_W     = HIST_AW;

	localparam logic [HIST_AW-1:0] IDX_ONE  = HIST_AW'(1);
	localparam logic [HIST_AW-1:0] IDX_LAST = HIST_AW'(HIST_FRAMES - 1);

	// Saturation limits and truncation bias, in sum width
	localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN  = -SUM_W'(2 ** (SAMPLE_W - 1));
	localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'((2 ** GAIN_FRAC) - 1);

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY = 2'd0,
		REG_DRY   = 2'd1,
		REG_WET   = 2'd2
	} cfg_reg_t;

	localparam logic [DELAY_W-1:0]       DELAY_RST = DELAY_W'(1024);
	localparam logic signed [GAIN_W-1:0] DRY_RST   = GAIN_W'(16384);
	localparam logic signed [GAIN_W-1:0] WET_RST   = GAIN_W'(8192);

	// Pipeline advance strobes shared by both lanes
	typedef struct packed {
		logic acc;      // transaction accepted into stage 1
		logic fire_s1;  // stage 1 moves into stage 2
		logic fire_s2;  // stage 2 commits to history and output
	} sfe_ctl_t;

endpackage

@@ rtl/sfe_lane.sv @@
// ----------------------------------------------------------------------------
// sfe_lane
// One channel of the echo: circular history memory, write forwarding and the
// dry/wet multiply-accumulate with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module sfe_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sfe_pkg::sfe_ctl_t                     ctl,
	input  logic signed [sfe_pkg::SAMPLE_W-1:0]   x,
	input  logic [sfe_pkg::HIST_AW-1:0]           rd_addr,
	input  logic [sfe_pkg::HIST_AW-1:0]           wr_addr,
	input  logic                                  rd_zero,
	input  logic signed [sfe_pkg::GAIN_W-1:0]     dry_gain,
	input  logic signed [sfe_pkg::GAIN_W-1:0]     wet_gain,
	output logic signed [sfe_pkg::SAMPLE_W-1:0]   y_s2
);
	import sfe_pkg::*;

	logic [SAMPLE_W-1:0] hist_mem [HIST_FRAMES];
	logic [SAMPLE_W-1:0] rd_data_q;

	logic signed [SAMPLE_W-1:0] x_s1;
	logic [HIST_AW-1:0]         ra_s1;
	logic [HIST_AW-1:0]         wa_s1;
	logic                       zero_s1;

	logic signed [PROD_W-1:0]   pdry_s2;
	logic [SAMPLE_W-1:0]        hmem_s2;
	logic [HIST_AW-1:0]         ra_s2;
	logic [HIST_AW-1:0]         wa_s2;
	logic                       zero_s2;

	// Two most recent history writes
	logic                       w1_v_q, w2_v_q;
	logic [HIST_AW-1:0]         w1_a_q, w2_a_q;
	logic [SAMPLE_W-1:0]        w1_d_q, w2_d_q;

	logic signed [SAMPLE_W-1:0] h;
	logic signed [PROD_W-1:0]   pwet;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    biased;
	logic signed [SUM_W-1:0]    quot;

	// Write the committed sample into the history
	always_ff @(posedge clk) begin
		if (ctl.fire_s2) begin
			hist_mem[wa_s2] <= y_s2;
		end
	end

	// Read the delayed sample when a transaction enters
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			rd_data_q <= hist_mem[rd_addr];
		end
	end

	// Stage 1: hold sample and addresses
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			x_s1    <= x;
			ra_s1   <= rd_addr;
			wa_s1   <= wr_addr;
			zero_s1 <= rd_zero;
		end
	end

	// Stage 2: register dry product and memory data
	always_ff @(posedge clk) begin
		if (ctl.fire_s1) begin
			pdry_s2 <= x_s1 * dry_gain;
			hmem_s2 <= rd_data_q;
			ra_s2   <= ra_s1;
			wa_s2   <= wa_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Track the last two writes for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_v_q <= 1'b0;
			w2_v_q <= 1'b0;
		end else if (ctl.fire_s2) begin
			w1_v_q <= 1'b1;
			w2_v_q <= w1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire_s2) begin
			w1_a_q <= wa_s2;
			w1_d_q <= y_s2;
			w2_a_q <= w1_a_q;
			w2_d_q <= w1_d_q;
		end
	end

	// Select the delayed sample: newest write first, unwritten slots read zero
	always_comb begin
		if (w1_v_q && (w1_a_q == ra_s2)) begin
			h = signed'(w1_d_q);
		end else if (w2_v_q && (w2_a_q == ra_s2)) begin
			h = signed'(w2_d_q);
		end else if (zero_s2) begin
			h = '0;
		end else begin
			h = signed'(hmem_s2);
		end
	end

	// Accumulate, truncate toward zero, saturate
	always_comb begin
		pwet   = h * wet_gain;
		sum    = SUM_W'(pdry_s2) + SUM_W'(pwet);
		biased = sum[SUM_W-1] ? (sum + RND_BIAS) : sum;
		quot   = biased >>> GAIN_FRAC;
		if (quot > SAT_MAX) begin
			y_s2 = SAT_MAX[SAMPLE_W-1:0];
		end else if (quot < SAT_MIN) begin
			y_s2 = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			y_s2 = quot[SAMPLE_W-1:0];
		end
	end

endmodule

@@ rtl/stereo_feedback_echo.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_echo
// Recursive stereo echo: two channel lanes with circular histories, shared
// pipeline control, configuration registers and a merged output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one stereo frame per transaction;
//   output channel (out_valid/out_ready) returns exactly one frame for each.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 delay_frames, 1 dry_gain, 2 wet_gain, others ignored.
//   Write configuration only while no frame is in flight.
// Path: a frame accepted into stage 1 moves through stage 2 and then the
//   output register before it is presented on the output; a stall can hold
//   it in any of these registers.
// Throughput: one frame per cycle while out_ready is high. The limit is the
//   stage 2 loop, where a delay of one frame feeds the previous output back
//   through the forwarding registers into the wet multiply-accumulate.
// Reset: gains and delay take their defaults, the write index returns to
//   zero and history slots not yet written since reset read as zero through
//   a fill mark (write index plus wrap flag); no clearing pass, so frames are
//   accepted as soon as reset is released.
// Stall: when out_ready is low the output register holds; empty stages keep
//   filling, so up to three frames are held before in_ready drops.
// ----------------------------------------------------------------------------
module stereo_feedback_echo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input frames
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sfe_pkg::SAMPLE_W-1:0]   left_in,
	input  logic signed [sfe_pkg::SAMPLE_W-1:0]   right_in,
	input  logic                                  block_end_in,
	// output frames
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sfe_pkg::SAMPLE_W-1:0]   left_out,
	output logic signed [sfe_pkg::SAMPLE_W-1:0]   right_out,
	output logic                                  block_end_out,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sfe_pkg::GAIN_W-1:0]            cfg_data
);
	import sfe_pkg::*;

	logic [DELAY_W-1:0]       delay_q;
	logic signed [GAIN_W-1:0] dry_q;
	logic signed [GAIN_W-1:0] wet_q;

	logic [HIST_AW-1:0] acc_idx_q;
	logic               wrapped_q;

	logic v_s1, v_s2;
	logic be_s1, be_s2;

	logic                       out_v_q;
	logic signed [SAMPLE_W-1:0] left_q, right_q;
	logic                       be_q;

	sfe_ctl_t ctl;
	logic     out_free, s2_free;

	logic [HIST_AW-1:0]         ra_l, ra_r;
	logic                       zero_l, zero_r;
	logic signed [SAMPLE_W-1:0] y_l, y_r;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			dry_q   <= DRY_RST;
			wet_q   <= WET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
				REG_DRY:   dry_q   <= signed'(cfg_data);
				REG_WET:   wet_q   <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// Pipeline advance: a stage moves when the next one is empty or moving
	always_comb begin
		out_free    = !out_v_q || out_ready;
		ctl.fire_s2 = v_s2 && out_free;
		s2_free     = !v_s2 || ctl.fire_s2;
		ctl.fire_s1 = v_s1 && s2_free;
		in_ready    = !v_s1 || ctl.fire_s1;
		ctl.acc     = in_valid && in_ready;
	end

	// Read addresses and fill mark
	always_comb begin
		ra_l   = acc_idx_q - HIST_AW'(delay_q);
		ra_r   = ra_l - IDX_ONE;
		zero_l = !wrapped_q && (ra_l >= acc_idx_q);
		zero_r = !wrapped_q && (ra_r >= acc_idx_q);
	end

	// Advance the write index per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_idx_q <= '0;
			wrapped_q <= 1'b0;
		end else if (ctl.acc) begin
			acc_idx_q <= acc_idx_q + IDX_ONE;
			if (acc_idx_q == IDX_LAST) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= ctl.fire_s1;
			end
			if (out_free) begin
				out_v_q <= ctl.fire_s2;
			end
		end
	end

	// Carry the block end marker alongside the lanes
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			be_s1 <= block_end_in;
		end
		if (ctl.fire_s1) begin
			be_s2 <= be_s1;
		end
	end

	sfe_lane u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.x        (left_in),
		.rd_addr  (ra_l),
		.wr_addr  (acc_idx_q),
		.rd_zero  (zero_l),
		.dry_gain (dry_q),
		.wet_gain (wet_q),
		.y_s2     (y_l)
	);

	sfe_lane u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.x        (right_in),
		.rd_addr  (ra_r),
		.wr_addr  (acc_idx_q),
		.rd_zero  (zero_r),
		.dry_gain (dry_q),
		.wet_gain (wet_q),
		.y_s2     (y_r)
	);

	// Merge lane results into the output register
	always_ff @(posedge clk) begin
		if (ctl.fire_s2) begin
			left_q  <= y_l;
			right_q <= y_r;
			be_q    <= be_s2;
		end
	end

	assign out_valid     = out_v_q;
	assign left_out      = left_q;
	assign right_out     = right_q;
	assign block_end_out = be_q;

	// Write index steps by one per accepted transaction
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc |=> ((acc_idx_q - $past(acc_idx_q)) == IDX_ONE))
		else $error("write index did not advance by one");

	// Fill mark never clears once the history has wrapped
	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrapped_q))
		else $error("history wrap flag dropped");

	// A frame leaving stage 1 lands in stage 2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire_s1 |=> v_s2)
		else $error("frame lost between stage 1 and stage 2");

	// A stalled stage 2 frame is held
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ctl.fire_s2) |=> v_s2)
		else $error("stalled stage 2 frame dropped");

	// A committed frame always reaches the output register
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire_s2 |=> out_v_q)
		else $error("committed frame missing at output");

endmodule

@@ dv/tb_stereo_feedback_echo.sv @@
// ----------------------------------------------------------------------------
// tb_stereo_feedback_echo
// Self-checking bench for the recursive stereo echo. A directed table checks
// reset state, gain extremes, truncation, saturation, delay extremes and the
// unmapped register index. Randomized phases follow, each after optional
// random register writes. Every accepted frame runs through a local model
// of the echo with its own history, and each returned frame is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_echo;
	timeunit 1ns;
	timeprecision 1ps;

	import sfe_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_FRAMES = 1400;
	localparam int MAX_REPORTS   = 10;

	// unmapped register index, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       block_end;
	} echo_frame_t;

	typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CFG_IDX_W-1:0]       reg_index;
		logic [GAIN_W-1:0]          reg_value;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       block_end;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] left_exp;
		logic signed [SAMPLE_W-1:0] right_exp;
	} stim_row_t;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_EVERY_THIRD} sink_mode_t;

	// DUT connections, inputs driven from time zero
	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_in      = '0;
	logic signed [SAMPLE_W-1:0] right_in     = '0;
	logic                       block_end_in = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       block_end_out;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [GAIN_W-1:0]          cfg_data     = '0;

	// sideband for directed rows with hand-written expectations
	logic                       frame_typed  = 1'b0;
	logic signed [SAMPLE_W-1:0] typed_left   = '0;
	logic signed [SAMPLE_W-1:0] typed_right  = '0;

	// handshake flags seen at the last rising edge
	logic in_fire  = 1'b0;
	logic cfg_fire = 1'b0;

	logic hold_request = 1'b0;
	logic hold_done    = 1'b0;

	int cycle_count    = 0;
	int mismatch_count = 0;

	// local echo state
	logic signed [SAMPLE_W-1:0] left_hist  [HIST_FRAMES];
	logic signed [SAMPLE_W-1:0] right_hist [HIST_FRAMES];
	logic [HIST_AW-1:0]         hist_wr_idx = '0;
	logic [DELAY_W-1:0]         echo_delay  = DELAY_RST;
	logic signed [GAIN_W-1:0]   dry_gain    = DRY_RST;
	logic signed [GAIN_W-1:0]   wet_gain    = WET_RST;

	echo_frame_t expected_frames [$];
	stim_row_t   directed_rows [$];

	stereo_feedback_echo uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_in       (left_in),
		.right_in      (right_in),
		.block_end_in  (block_end_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_out      (left_out),
		.right_out     (right_out),
		.block_end_out (block_end_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mix one sample with its echo tap, truncate toward zero, clip to sample range
	function automatic logic signed [SAMPLE_W-1:0] mix_and_clip(input longint x, input longint h);
		longint acc;
		longint top;
		top = (longint'(1) << (SAMPLE_W - 1)) - 1;
		acc = (x * longint'(dry_gain) + h * longint'(wet_gain)) / (longint'(1) << GAIN_FRAC);
		if (acc > top)
			acc = top;
		else if (acc < -top - 1)
			acc = -top - 1;
		return SAMPLE_W'(acc);
	endfunction

	// Compute one output frame and write it back into the history
	function automatic echo_frame_t compute_echo_frame(input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r, input logic be);
		echo_frame_t        y;
		logic [HIST_AW-1:0] tap_l;
		logic [HIST_AW-1:0] tap_r;
		tap_l = hist_wr_idx - echo_delay;
		tap_r = hist_wr_idx - echo_delay - IDX_ONE;
		y.left      = mix_and_clip(longint'(l), longint'(left_hist[tap_l]));
		y.right     = mix_and_clip(longint'(r), longint'(right_hist[tap_r]));
		y.block_end = be;
		left_hist[hist_wr_idx]  = y.left;
		right_hist[hist_wr_idx] = y.right;
		hist_wr_idx = hist_wr_idx + IDX_ONE;
		return y;
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		stim_row_t row;
		row = '{kind: ROW_WRITE, default: '0};
		row.kind      = ROW_WRITE;
		row.reg_index = idx;
		row.reg_value = val;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void add_frame(input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r, input logic be, input logic typed,
		input logic signed [SAMPLE_W-1:0] le, input logic signed [SAMPLE_W-1:0] re);
		stim_row_t row;
		row = '{kind: ROW_FRAME, default: '0};
		row.kind      = ROW_FRAME;
		row.left      = l;
		row.right     = r;
		row.block_end = be;
		row.typed     = typed;
		row.left_exp  = le;
		row.right_exp = re;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Track handshakes and keep the local model in step with the DUT
	always @(posedge clk) begin
		echo_frame_t y;
		in_fire  <= arst_n && in_valid && in_ready;
		cfg_fire <= arst_n && cfg_valid && cfg_ready;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DELAY: echo_delay = cfg_data[DELAY_W-1:0];
				REG_DRY:   dry_gain   = cfg_data;
				REG_WET:   wet_gain   = cfg_data;
				default:   ;
			endcase
		end
		if (arst_n && in_valid && in_ready) begin
			y = compute_echo_frame(left_in, right_in, block_end_in);
			if (frame_typed) begin
				y.left  = typed_left;
				y.right = typed_right;
			end
			expected_frames = {expected_frames, y};
		end
	end

	// Compare each returned transaction with the oldest expectation
	always @(posedge clk) begin
		echo_frame_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				note_failure($sformatf("unexpected frame L=%0d R=%0d end=%0b",
					left_out, right_out, block_end_out));
			end else begin
				e = expected_frames.pop_front();
				if (left_out !== e.left || right_out !== e.right ||
					block_end_out !== e.block_end)
					note_failure($sformatf("exp L=%0d R=%0d end=%0b got L=%0d R=%0d end=%0b",
						e.left, e.right, e.block_end, left_out, right_out, block_end_out));
			end
		end
	end

	// Hard stop on a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Output back-pressure: one long hold-off on request, otherwise random segments
	initial begin : sink
		sink_mode_t mode;
		int         span;
		int         tick;
		tick = 0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				mode = sink_mode_t'($urandom_range(0, 3));
				span = $urandom_range(8, 60);
				repeat (span) begin
					@(negedge clk);
					tick++;
					case (mode)
						SINK_OPEN:   out_ready <= 1'b1;
						SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
						SINK_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
						default:     out_ready <= (tick % 3 == 0);
					endcase
				end
			end
		end
	end

	// Present one frame and hold it until the transaction completes
	task automatic offer_frame(input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r, input logic be, input logic typed,
		input logic signed [SAMPLE_W-1:0] le, input logic signed [SAMPLE_W-1:0] re);
		in_valid     <= 1'b1;
		left_in      <= l;
		right_in     <= r;
		block_end_in <= be;
		frame_typed  <= typed;
		typed_left   <= le;
		typed_right  <= re;
		do @(negedge clk); while (!in_fire);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_fire);
	endtask

	// Drop input valid and let every frame in flight come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_frames.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic                 prev_write;
		logic                 no_gaps;
		logic [DELAY_W-1:0]   d;
		int                   random_sent;
		int                   phase_len;
		int                   sent;
		int                   burst;
		int                   gap;
		bit                   first_phase;

		for (int i = 0; i < HIST_FRAMES; i++) begin
			left_hist[i]  = '0;
			right_hist[i] = '0;
		end

		// after reset: unity dry, empty history
		add_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
		add_frame(16'sd0, 16'sd0, 1'b0, 1'b1, 16'sd0, 16'sd0);
		add_frame(-16'sd1, 16'sd1, 1'b0, 1'b1, -16'sd1, 16'sd1);
		// largest dry gain, no echo: saturation
		add_write(REG_DRY, 16'h7FFF);
		add_write(REG_WET, 16'h0000);
		add_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
		add_frame(16'sd1, -16'sd1, 1'b0, 1'b1, 16'sd1, -16'sd1);
		// most negative dry gain
		add_write(REG_DRY, 16'h8000);
		add_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 16'sh8000, 16'sh7FFF);
		add_frame(16'sd1, -16'sd1, 1'b1, 1'b1, -16'sd2, 16'sd2);
		// tiny gain: truncation goes toward zero
		add_write(REG_DRY, 16'h0001);
		add_frame(-16'sd1, 16'sh7FFF, 1'b0, 1'b1, 16'sd0, 16'sd1);
		add_frame(-16'sd32767, 16'sh8000, 1'b0, 1'b1, -16'sd1, -16'sd2);
		// one-frame echo at unity feedback: recursion and saturation through history
		add_write(REG_DELAY, 16'h0001);
		add_write(REG_DRY, 16'h4000);
		add_write(REG_WET, 16'h4000);
		add_frame(16'sd20000, -16'sd20000, 1'b0, 1'b0, '0, '0);
		add_frame(16'sd20000, -16'sd20000, 1'b0, 1'b0, '0, '0);
		add_frame(16'sd20000, -16'sd20000, 1'b1, 1'b0, '0, '0);
		add_frame(16'sd0, 16'sd0, 1'b0, 1'b0, '0, '0);
		// most negative and largest wet gain
		add_write(REG_WET, 16'h8000);
		add_frame(16'sd100, -16'sd100, 1'b0, 1'b0, '0, '0);
		add_frame(16'sd0, 16'sd0, 1'b0, 1'b0, '0, '0);
		add_frame(16'sd0, 16'sd0, 1'b1, 1'b0, '0, '0);
		add_write(REG_WET, 16'h7FFF);
		add_frame(16'sd3000, 16'sd3000, 1'b0, 1'b0, '0, '0);
		// zero delay, then the longest delay; upper data bits must be ignored
		add_write(REG_DELAY, 16'hF000);
		add_frame(16'sd1234, -16'sd4321, 1'b0, 1'b0, '0, '0);
		add_frame(16'sd77, 16'sd88, 1'b1, 1'b0, '0, '0);
		add_write(REG_DELAY, 16'h0FFF);
		add_frame(16'sd500, -16'sd500, 1'b0, 1'b0, '0, '0);
		add_frame(-16'sd600, 16'sd600, 1'b0, 1'b0, '0, '0);
		// write to the unmapped index leaves all registers alone
		add_write(REG_DRY, 16'h4000);
		add_write(REG_WET, 16'h0000);
		add_write(REG_SPARE, 16'hFFFF);
		add_frame(16'sd5, -16'sd5, 1'b1, 1'b1, 16'sd5, -16'sd5);

		// hold reset, then release it on a falling edge
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		prev_write = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (!prev_write)
					wait_drained();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
				prev_write = 1'b1;
			end else begin
				if (prev_write)
					cfg_valid <= 1'b0;
				offer_frame(directed_rows[i].left, directed_rows[i].right,
					directed_rows[i].block_end, directed_rows[i].typed,
					directed_rows[i].left_exp, directed_rows[i].right_exp);
				prev_write = 1'b0;
			end
		end

		// random phases, each preceded by optional register writes
		random_sent = 0;
		first_phase = 1'b1;
		while (random_sent < RANDOM_FRAMES) begin
			wait_drained();
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       d = '0;
					1:       d = '1;
					2, 3:    d = DELAY_W'($urandom);
					default: d = DELAY_W'($urandom_range(1, 8));
				endcase
				write_reg(REG_DELAY, {4'($urandom), d});
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       write_reg(REG_DRY, 16'h8000);
					1:       write_reg(REG_DRY, 16'h7FFF);
					default: write_reg(REG_DRY, 16'($urandom));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:          write_reg(REG_WET, 16'h8000);
					1:          write_reg(REG_WET, 16'h7FFF);
					2, 3, 4, 5: write_reg(REG_WET, 16'(int'($urandom_range(0, 24000)) - 12000));
					default:    write_reg(REG_WET, 16'($urandom));
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, 16'($urandom));
			cfg_valid <= 1'b0;

			// first phase is long and runs into the long output hold-off
			if (first_phase) begin
				phase_len    = 200;
				hold_request = 1'b1;
				first_phase  = 1'b0;
			end else begin
				phase_len = $urandom_range(20, 120);
			end
			no_gaps = ($urandom_range(0, 3) == 0);

			sent = 0;
			while (sent < phase_len) begin
				burst = $urandom_range(1, 16);
				repeat (burst) begin
					offer_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)),
						1'b0, '0, '0);
					sent++;
				end
				// the drain at the end of the phase drops valid itself
				gap = no_gaps ? 0 : $urandom_range(0, 6);
				if (gap != 0 && sent < phase_len) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			random_sent += sent;
		end

		// flush and report
		wait_drained();
		if (expected_frames.size() != 0)
			note_failure($sformatf("%0d frames never returned", expected_frames.size()));
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
